// ===== rtl/core/aescbc_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-128 CBC package
// S-box tables, GF helpers and command/status types shared by the block.
// ----------------------------------------------------------------------------
package aescbc_pkg;

	localparam int NUM_ROUNDS = 10;

	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_KEY_HI = 3'd1;
	localparam logic [2:0] REG_KEY_LO = 3'd2;
	localparam logic [2:0] REG_IV_HI  = 3'd3;
	localparam logic [2:0] REG_IV_LO  = 3'd4;

	typedef struct packed {
		logic       key_start;   // load cipher key, begin expansion
		logic       key_step;    // derive next round key
		logic       blk_load;    // capture input block, whiten
		logic       round_step;  // run one round
		logic       out_load;    // capture result
	} ctl_cmd_t;

	typedef struct packed {
		logic       key_done;
		logic       last_round;
	} ctl_sts_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
		logic [7:0] r;
		logic [7:0] p;
		r = '0;
		p = a;
		for (int i = 0; i < 4; i++) begin
			if (b[i]) r = r ^ p;
			p = xtime(p);
		end
		gmul = r;
	endfunction

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		sbox = t[x];
	endfunction

	// inverse S-box table
	function automatic logic [7:0] inv_sbox(input logic [7:0] y);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		inv_sbox = t[y];
	endfunction

	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				t[127-8*(r+4*c) -: 8] = sbox(s[127-8*(r+4*((c+r)%4)) -: 8]);
		sub_shift = t;
	endfunction

	function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
		logic [127:0] t;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				t[127-8*(r+4*((c+r)%4)) -: 8] = inv_sbox(s[127-8*(r+4*c) -: 8]);
		inv_shift_sub = t;
	endfunction

	function automatic logic [127:0] mix_cols(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127-32*c -: 8];
			a1 = s[119-32*c -: 8];
			a2 = s[111-32*c -: 8];
			a3 = s[103-32*c -: 8];
			t[127-32*c -: 8] = gmul(a0, 4'd2) ^ gmul(a1, 4'd3) ^ a2 ^ a3;
			t[119-32*c -: 8] = a0 ^ gmul(a1, 4'd2) ^ gmul(a2, 4'd3) ^ a3;
			t[111-32*c -: 8] = a0 ^ a1 ^ gmul(a2, 4'd2) ^ gmul(a3, 4'd3);
			t[103-32*c -: 8] = gmul(a0, 4'd3) ^ a1 ^ a2 ^ gmul(a3, 4'd2);
		end
		mix_cols = t;
	endfunction

	function automatic logic [127:0] inv_mix_cols(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127-32*c -: 8];
			a1 = s[119-32*c -: 8];
			a2 = s[111-32*c -: 8];
			a3 = s[103-32*c -: 8];
			t[127-32*c -: 8] = gmul(a0,4'd14)^gmul(a1,4'd11)^gmul(a2,4'd13)^gmul(a3,4'd9);
			t[119-32*c -: 8] = gmul(a0,4'd9)^gmul(a1,4'd14)^gmul(a2,4'd11)^gmul(a3,4'd13);
			t[111-32*c -: 8] = gmul(a0,4'd13)^gmul(a1,4'd9)^gmul(a2,4'd14)^gmul(a3,4'd11);
			t[103-32*c -: 8] = gmul(a0,4'd11)^gmul(a1,4'd13)^gmul(a2,4'd9)^gmul(a3,4'd14);
		end
		inv_mix_cols = t;
	endfunction

endpackage

// ===== rtl/core/aescbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// AES-128 CBC controller
// Sequences key expansion, rounds and result handoff.
// ----------------------------------------------------------------------------
module aescbc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  key_write,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  aescbc_pkg::ctl_sts_t  sts,
	output aescbc_pkg::ctl_cmd_t  cmd
);
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_KEY   = 2'd1;
	localparam logic [1:0] ST_ROUND = 2'd2;

	logic [1:0] state_q;
	logic       key_pend_q;
	logic       out_valid_q;
	logic       take;

	// one block in flight; output register free or being drained
	assign in_ready  = (state_q == ST_IDLE) && !key_pend_q && (!out_valid_q || out_ready);
	assign take      = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.key_start  = (state_q == ST_IDLE) && key_pend_q;
		cmd.key_step   = (state_q == ST_KEY) && !sts.key_done;
		cmd.blk_load   = take;
		cmd.round_step = (state_q == ST_ROUND);
		cmd.out_load   = (state_q == ST_ROUND) && sts.last_round;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_pend_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (key_pend_q) begin
						state_q    <= ST_KEY;
						key_pend_q <= 1'b0;
					end else if (take) begin
						state_q <= ST_ROUND;
					end
				end
				ST_KEY: begin
					if (sts.key_done) state_q <= ST_IDLE;
				end
				ST_ROUND: begin
					if (sts.last_round) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (key_write) key_pend_q <= 1'b1;
		end
	end
endmodule

// ===== rtl/core/aescbc_dp.sv =====
// ----------------------------------------------------------------------------
// AES-128 CBC datapath
// Round key memory, key schedule, round unit and chain register.
// ----------------------------------------------------------------------------
module aescbc_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  aescbc_pkg::ctl_cmd_t  cmd,
	output aescbc_pkg::ctl_sts_t  sts,
	input  logic                  decrypt,
	input  logic [127:0]          key,
	input  logic [127:0]          iv,
	input  logic [127:0]          blk,
	input  logic                  som,
	output logic [127:0]          result
);
	// forward round keys 0..10 in enc, inverse-mix keys for decrypt
	logic [127:0] rk_mem [11];
	logic [127:0] dk_mem [11];
	logic [127:0] kw_q;
	logic [7:0]   rcon_q;
	logic [3:0]   kidx_q;
	logic [3:0]   ridx_q;
	logic [127:0] state_q;
	logic [127:0] chain_q;
	logic [127:0] result_q;
	logic         dec_q;
	logic [127:0] rkey_q;
	logic [127:0] knext;
	logic [31:0]  w0, w1, w2, w3, tw;
	logic [127:0] rnd_in;
	logic [127:0] rnd_out;
	logic [127:0] chain_use;

	assign w3 = kw_q[31:0];
	assign tw = {aescbc_pkg::sbox(w3[23:16]) ^ rcon_q, aescbc_pkg::sbox(w3[15:8]),
		aescbc_pkg::sbox(w3[7:0]), aescbc_pkg::sbox(w3[31:24])};
	assign w0 = kw_q[127:96] ^ tw;
	assign w1 = kw_q[95:64] ^ w0;
	assign w2 = kw_q[63:32] ^ w1;
	assign knext = {w0, w1, w2, w2 ^ w3};

	assign sts.key_done   = (kidx_q == 4'(aescbc_pkg::NUM_ROUNDS));
	assign sts.last_round = (ridx_q == 4'(aescbc_pkg::NUM_ROUNDS));

	always_comb begin
		if (dec_q) begin
			rnd_in = aescbc_pkg::inv_shift_sub(state_q);
			if (ridx_q != 4'(aescbc_pkg::NUM_ROUNDS)) rnd_in = aescbc_pkg::inv_mix_cols(rnd_in);
		end else begin
			rnd_in = aescbc_pkg::sub_shift(state_q);
			if (ridx_q != 4'(aescbc_pkg::NUM_ROUNDS)) rnd_in = aescbc_pkg::mix_cols(rnd_in);
		end
		rnd_out = rnd_in ^ rkey_q;
	end

	assign chain_use = som ? iv : chain_q;
	assign result    = result_q;

	always_ff @(posedge clk) begin
		if (cmd.key_start) begin
			kw_q      <= key;
			rk_mem[0] <= key;
			dk_mem[0] <= key;
		end else if (cmd.key_step) begin
			kw_q <= knext;
			rk_mem[kidx_q + 4'd1] <= knext;
			dk_mem[kidx_q + 4'd1] <= aescbc_pkg::inv_mix_cols(knext);
		end
		// fetch the round key one round ahead
		if (cmd.blk_load) begin
			rkey_q <= decrypt ? dk_mem[aescbc_pkg::NUM_ROUNDS - 1] : rk_mem[1];
		end else if (cmd.round_step && !sts.last_round) begin
			if (dec_q) begin
				rkey_q <= (ridx_q == 4'(aescbc_pkg::NUM_ROUNDS - 1)) ? rk_mem[0] :
					dk_mem[4'(aescbc_pkg::NUM_ROUNDS - 1) - ridx_q];
			end else begin
				rkey_q <= rk_mem[ridx_q + 4'd1];
			end
		end
		if (cmd.blk_load) begin
			dec_q <= decrypt;
			if (decrypt) begin
				state_q <= blk ^ rk_mem[aescbc_pkg::NUM_ROUNDS];
				result_q <= chain_use; // hold prior chain for final XOR
			end else begin
				state_q <= blk ^ chain_use ^ rk_mem[0];
			end
		end else if (cmd.round_step) begin
			state_q <= rnd_out;
		end
		if (cmd.out_load) begin
			if (dec_q) begin
				result_q <= rnd_out ^ result_q;
			end else begin
				result_q <= rnd_out;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kidx_q  <= '0;
			rcon_q  <= 8'h01;
			ridx_q  <= '0;
			chain_q <= '0;
		end else begin
			if (cmd.key_start) begin
				kidx_q <= '0;
				rcon_q <= 8'h01;
			end else if (cmd.key_step) begin
				kidx_q <= kidx_q + 4'd1;
				rcon_q <= aescbc_pkg::xtime(rcon_q);
			end
			if (cmd.blk_load) ridx_q <= 4'd1;
			else if (cmd.round_step) ridx_q <= ridx_q + 4'd1;
			// decrypt chains on the ciphertext in, encrypt on the ciphertext out
			if (cmd.blk_load && decrypt) chain_q <= blk;
			else if (cmd.out_load && !dec_q) chain_q <= rnd_out;
		end
	end
endmodule

// ===== rtl/core/aes128_cbc_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// AES-128 CBC cipher unit
// Encrypts or decrypts 16-byte blocks in CBC mode over stream channels.
// ----------------------------------------------------------------------------
// One block is in flight at a time: a transfer on s_axis starts it, ten
// iterations of a shared round unit run one per cycle, and the result sits in
// an output register for m_axis. The next block is taken once the controller is
// back in idle with the output register free or being drained; a result that
// waits on m_axis_tready holds off the next block. After reset and after any
// key write, the first block waits while the key schedule fills the round key
// memory, one round key a cycle. Write configuration only while idle. An IV
// takes effect at the next block that carries the start-of-message flag in
// tuser. The chain value resets to zero.
module aes128_cbc_cipher_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // block_hi [63:0], block_lo [127:64]
	input  logic         s_axis_tuser,   // start_of_message
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata    // result_hi [63:0], result_lo [127:64]
);
	logic                 mode_q;
	logic [63:0]          key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
	logic                 key_write;
	logic [127:0]         res;
	aescbc_pkg::ctl_cmd_t cmd;
	aescbc_pkg::ctl_sts_t sts;

	// hold configuration registers; a key write forces re-expansion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			key_hi_q <= '0;
			key_lo_q <= '0;
			iv_hi_q  <= '0;
			iv_lo_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				aescbc_pkg::REG_MODE:   mode_q   <= cfg_data[0];
				aescbc_pkg::REG_KEY_HI: key_hi_q <= cfg_data;
				aescbc_pkg::REG_KEY_LO: key_lo_q <= cfg_data;
				aescbc_pkg::REG_IV_HI:  iv_hi_q  <= cfg_data;
				aescbc_pkg::REG_IV_LO:  iv_lo_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign key_write = cfg_we && (cfg_index == aescbc_pkg::REG_KEY_HI ||
		cfg_index == aescbc_pkg::REG_KEY_LO);

	aescbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_write (key_write),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// wire order: block_hi in the low half
	aescbc_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.decrypt (mode_q),
		.key     ({key_hi_q, key_lo_q}),
		.iv      ({iv_hi_q, iv_lo_q}),
		.blk     ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
		.som     (s_axis_tuser),
		.result  (res)
	);

	// wire order: result_hi in the low half
	assign m_axis_tdata = {res[63:0], res[127:64]};
endmodule

// ===== rtl/core/aescbc_checker.sv =====
// ----------------------------------------------------------------------------
// AES-128 CBC port checker
// Watches the stream ports of the cipher unit over time.
// ----------------------------------------------------------------------------
module aescbc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata
);
	// result held while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed under stall");

	// a waiting result holds off the next block
	a_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("block taken while result waits");

	// one block in flight: not ready the cycle after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second block taken while busy");

	// result appears only after all ten rounds
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid [*10])
		else $error("result too early");
endmodule

bind aes128_cbc_cipher_unit aescbc_checker u_aescbc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// AES-128 CBC cipher unit testbench
// Drives blocks over the input stream and checks every output transfer
// against a built-in CBC cipher model, with random gaps, stalls and
// configuration changes between phases.
// ----------------------------------------------------------------------------
module tb;

	typedef logic [7:0] state_bytes_t [16];

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
	} cipher_block_t;

	// index beyond the last register; the block must ignore it
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	// key schedule fill plus one full block
	localparam int KEY_SETTLE = 30;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [63:0]  cfg_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;   // block_hi [63:0], block_lo [127:64]
	logic         s_axis_tuser;   // start_of_message
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [127:0] m_axis_tdata;   // result_hi [63:0], result_lo [127:64]

	aes128_cbc_cipher_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// cipher model state: shadow registers, chain value, round keys
	logic [7:0]    fwd_sub [256];
	logic [7:0]    rev_sub [256];
	logic          mdl_decrypt;
	logic [127:0]  mdl_key;
	logic [127:0]  mdl_iv;
	logic [127:0]  mdl_chain;
	logic [127:0]  mdl_round_key [11];
	logic          mdl_key_stale;

	cipher_block_t pending_results [$];
	int            fail_count;
	int            cycle_count;
	bit            no_idle;      // when set, neither side inserts gaps
	int            hold_left;    // long receiver hold-off, counted in cycles
	int            stall_left;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// --------------------------------------------------------------------
	// GF(2^8) and AES round helpers
	// --------------------------------------------------------------------
	function automatic logic [7:0] gf_double(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc ^= a;
			a = gf_double(a);
		end
		return acc;
	endfunction

	function automatic logic [7:0] rot_byte(input logic [7:0] v, input int s);
		return (v << s) | (v >> (8 - s));
	endfunction

	// build the S-box from the field inverse and the affine map
	task automatic build_sub_tables();
		logic [7:0] inv;
		logic [7:0] pw;
		logic [7:0] y;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h01;
			pw = x[7:0];
			for (int e = 0; e < 8; e++) begin
				if (e != 0) inv = gf_product(inv, pw);  // x^254 = product of x^2..x^128
				pw = gf_product(pw, pw);
			end
			if (x == 0) inv = 8'h00;
			y = inv ^ rot_byte(inv, 1) ^ rot_byte(inv, 2) ^ rot_byte(inv, 3)
				^ rot_byte(inv, 4) ^ 8'h63;
			fwd_sub[x] = y;
			rev_sub[y] = x[7:0];
		end
	endtask

	function automatic state_bytes_t split_bytes(input logic [127:0] v);
		state_bytes_t b;
		for (int i = 0; i < 16; i++) b[i] = v[127 - 8 * i -: 8];
		return b;
	endfunction

	function automatic logic [127:0] join_bytes(input state_bytes_t b);
		logic [127:0] v;
		for (int i = 0; i < 16; i++) v[127 - 8 * i -: 8] = b[i];
		return v;
	endfunction

	function automatic logic [127:0] sub_and_shift(input logic [127:0] v);
		state_bytes_t s;
		state_bytes_t t;
		s = split_bytes(v);
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				t[r + 4 * c] = fwd_sub[s[r + 4 * ((c + r) % 4)]];
		return join_bytes(t);
	endfunction

	function automatic logic [127:0] unshift_and_unsub(input logic [127:0] v);
		state_bytes_t s;
		state_bytes_t t;
		s = split_bytes(v);
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				t[r + 4 * ((c + r) % 4)] = rev_sub[s[r + 4 * c]];
		return join_bytes(t);
	endfunction

	// forward (2,3,1,1) or inverse (14,11,13,9) column mix
	function automatic logic [127:0] mix_columns(input logic [127:0] v, input bit inverse);
		state_bytes_t s;
		state_bytes_t t;
		logic [7:0] m [4];
		if (inverse) m = '{8'd14, 8'd11, 8'd13, 8'd9};
		else m = '{8'd2, 8'd3, 8'd1, 8'd1};
		s = split_bytes(v);
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				t[4 * c + r] = 8'h00;
				for (int k = 0; k < 4; k++)
					t[4 * c + r] ^= gf_product(s[4 * c + k], m[(k - r + 4) % 4]);
			end
		return join_bytes(t);
	endfunction

	task automatic expand_cipher_key();
		logic [31:0] w [44];
		logic [31:0] t;
		logic [7:0]  rc;
		rc = 8'h01;
		for (int i = 0; i < 4; i++) w[i] = mdl_key[127 - 32 * i -: 32];
		for (int i = 4; i < 44; i++) begin
			t = w[i - 1];
			if (i % 4 == 0) begin
				t = {fwd_sub[t[23:16]] ^ rc, fwd_sub[t[15:8]], fwd_sub[t[7:0]],
					fwd_sub[t[31:24]]};
				rc = gf_double(rc);
			end
			w[i] = w[i - 4] ^ t;
		end
		for (int r = 0; r < 11; r++)
			mdl_round_key[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
		mdl_key_stale = 1'b0;
	endtask

	// advance the chain by one block and return the block's result
	task automatic cbc_step(input logic [127:0] blk, input logic som,
			output logic [127:0] res);
		logic [127:0] s;
		if (mdl_key_stale) expand_cipher_key();
		if (som) mdl_chain = mdl_iv;
		if (mdl_decrypt) begin
			s = blk ^ mdl_round_key[10];
			for (int r = 9; r >= 1; r--)
				s = mix_columns(unshift_and_unsub(s) ^ mdl_round_key[r], 1'b1);
			s = unshift_and_unsub(s) ^ mdl_round_key[0];
			res = s ^ mdl_chain;
			mdl_chain = blk;
		end else begin
			s = blk ^ mdl_chain ^ mdl_round_key[0];
			for (int r = 1; r <= 9; r++)
				s = mix_columns(sub_and_shift(s), 1'b0) ^ mdl_round_key[r];
			res = sub_and_shift(s) ^ mdl_round_key[10];
			mdl_chain = res;
		end
	endtask

	// --------------------------------------------------------------------
	// Drivers
	// --------------------------------------------------------------------
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			aescbc_pkg::REG_MODE: mdl_decrypt = value[0];
			aescbc_pkg::REG_KEY_HI: begin
				mdl_key[127:64] = value;
				mdl_key_stale = 1'b1;
			end
			aescbc_pkg::REG_KEY_LO: begin
				mdl_key[63:0] = value;
				mdl_key_stale = 1'b1;
			end
			aescbc_pkg::REG_IV_HI: mdl_iv[127:64] = value;
			aescbc_pkg::REG_IV_LO: mdl_iv[63:0] = value;
			default: ;
		endcase
	endtask

	// offer one block; hold it until the transfer, then queue its result
	task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
			input logic som);
		int gap;
		logic [127:0] res;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {lo, hi};
		s_axis_tuser <= som;
		do @(posedge clk); while (!s_axis_tready);
		cbc_step({hi, lo}, som, res);
		pending_results.push_back('{hi: res[127:64], lo: res[63:0]});
	endtask

	// stop offering and wait until every result is out, plus a margin
	task automatic drain(input int margin);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (margin) @(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 64'h0;
			1: return '1;
			default: return rand64();
		endcase
	endfunction

	task automatic send_random_message(input int len);
		for (int i = 0; i < len; i++)
			send_block(rand_word(), rand_word(), i == 0);
	endtask

	task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
		write_reg(aescbc_pkg::REG_KEY_HI, hi);
		write_reg(aescbc_pkg::REG_KEY_LO, lo);
	endtask

	task automatic set_iv(input logic [63:0] hi, input logic [63:0] lo);
		write_reg(aescbc_pkg::REG_IV_HI, hi);
		write_reg(aescbc_pkg::REG_IV_LO, lo);
	endtask

	// --------------------------------------------------------------------
	// Receiver: random stalls between transfers, plus a long hold-off on
	// request; check each transfer against the oldest queued result
	// --------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cipher_block_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			stall_left = no_idle ? 0 : $urandom_range(0, 6);
			if (pending_results.size() == 0) begin
				$error("unexpected transfer: result_hi=%h result_lo=%h",
					m_axis_tdata[63:0], m_axis_tdata[127:64]);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[63:0] !== want.hi) begin
					$error("result_hi: expected %h, got %h", want.hi, m_axis_tdata[63:0]);
					fail_count++;
				end
				if (m_axis_tdata[127:64] !== want.lo) begin
					$error("result_lo: expected %h, got %h", want.lo, m_axis_tdata[127:64]);
					fail_count++;
				end
			end
		end
	end

	// hard stop for a hung block
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// --------------------------------------------------------------------
	// Tests
	// --------------------------------------------------------------------

	// first block after reset, no start flag: chain from zero, zero key
	task automatic test_reset_chain();
		send_block(64'h0, 64'h0, 1'b0);
		send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
		drain(KEY_SETTLE);
	endtask

	// field extremes with the all-ones key in both directions, then a counting key
	task automatic test_extremes();
		set_key('1, '1);
		set_iv('1, '1);
		send_block('1, '1, 1'b1);
		send_block(64'h0, 64'h0, 1'b0);
		send_block(64'h8000000000000000, 64'h0000000000000001, 1'b1);
		drain(KEY_SETTLE);
		write_reg(aescbc_pkg::REG_MODE, 64'h1);
		send_block('1, '1, 1'b1);
		send_block(64'h0, 64'h0, 1'b0);
		drain(KEY_SETTLE);
		set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
		set_iv(64'h0, 64'h0);
		write_reg(aescbc_pkg::REG_MODE, 64'h0);
		send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
		drain(KEY_SETTLE);
	endtask

	// mode flips mid-message keep the chain; ignored register index
	task automatic test_mode_switch();
		set_iv(64'h0123456789abcdef, 64'hfedcba9876543210);
		send_block(rand64(), rand64(), 1'b1);
		send_block(rand64(), rand64(), 1'b0);
		drain(KEY_SETTLE);
		write_reg(aescbc_pkg::REG_MODE, rand64() | 64'h1);
		send_block(rand64(), rand64(), 1'b0);
		send_block(rand64(), rand64(), 1'b0);
		drain(KEY_SETTLE);
		write_reg(REG_UNUSED, '1);
		write_reg(3'd5, rand64());
		write_reg(aescbc_pkg::REG_MODE, rand64() & ~64'h1);
		send_block(rand64(), rand64(), 1'b0);
		drain(KEY_SETTLE);
	endtask

	// a new IV is held until the next start flag
	task automatic test_iv_reload();
		send_block(rand64(), rand64(), 1'b1);
		drain(KEY_SETTLE);
		set_iv(rand64(), rand64());
		send_block(rand64(), rand64(), 1'b0);
		send_block(rand64(), rand64(), 1'b1);
		send_block(rand64(), rand64(), 1'b1);
		drain(KEY_SETTLE);
	endtask

	// hold the output for a long stretch so the input backs up, then run with no gaps
	task automatic test_backpressure();
		@(negedge clk);
		hold_left = 300;
		send_random_message(8);
		drain(KEY_SETTLE);
		no_idle = 1'b1;
		send_random_message(12);
		drain(KEY_SETTLE);
		no_idle = 1'b0;
	endtask

	// random messages across several key, IV and mode settings
	task automatic test_random();
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_key(64'h0, 64'h0);
				7: set_key('1, 64'h0);
				default: set_key(rand64(), rand64());
			endcase
			set_iv(rand_word(), rand_word());
			write_reg(aescbc_pkg::REG_MODE, (rand64() & ~64'h1) | 64'(phase[0]));
			no_idle = (phase == 3);
			for (int m = 0; m < 9; m++)
				send_random_message($urandom_range(1, 10));
			// a few stray blocks that restart or continue the chain at random
			for (int i = 0; i < 3; i++)
				send_block(rand64(), rand64(), 1'($urandom_range(0, 1)));
			drain(KEY_SETTLE);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		fail_count = 0;
		cycle_count = 0;
		no_idle = 1'b0;
		hold_left = 0;
		stall_left = 0;
		mdl_decrypt = 1'b0;
		mdl_key = '0;
		mdl_iv = '0;
		mdl_chain = '0;
		mdl_key_stale = 1'b1;
		build_sub_tables();
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_reset_chain();
		test_extremes();
		test_mode_switch();
		test_iv_reload();
		test_backpressure();
		test_random();

		drain(KEY_SETTLE);
		if (fail_count == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/aescbc_pkg.sv
rtl/core/aescbc_ctrl.sv
rtl/core/aescbc_dp.sv
rtl/core/aes128_cbc_cipher_unit.sv
rtl/core/aescbc_checker.sv
bench/tb.sv
